// ----- hw/rtl/cc_pkg.sv -----
// Shared types and constants for the circular convolution block.
package cc_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_BITS = 16;
    localparam int RESULT_BITS = 38;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;

    // Configuration port
    localparam int              LEN_BITS  = 7;
    localparam int              ADDR_BITS = 3;
    localparam int              DATA_BITS = 32;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;

    // Register index, taken from paddr above the byte offset
    localparam logic [ADDR_BITS-3:0] REG_BLOCK_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
    } cc_in_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] result_value;
        logic                          last_of_block;
    } cc_out_t;

    // Commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic compute;
        logic unload;
    } cc_cell_cmd_t;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_COMP  = 3'b010,
        S_DRAIN = 3'b100
    } cc_state_t;

endpackage

// ----- hw/rtl/cc_cell.sv -----
// One convolution cell: holds a sample pair and one output accumulator.
module cc_cell (
    input  logic                                  clk,
    input  cc_pkg::cc_cell_cmd_t                  cmd,
    input  logic                                  wr_en,
    input  cc_pkg::cc_in_t                        wr_data,
    input  logic signed [cc_pkg::SAMPLE_BITS-1:0] a_in,
    input  logic signed [cc_pkg::SAMPLE_BITS-1:0] b_in,
    input  logic signed [cc_pkg::RESULT_BITS-1:0] acc_in,
    input  logic signed [cc_pkg::SAMPLE_BITS-1:0] a_bcast,
    output logic signed [cc_pkg::SAMPLE_BITS-1:0] a_out,
    output logic signed [cc_pkg::SAMPLE_BITS-1:0] b_out,
    output logic signed [cc_pkg::RESULT_BITS-1:0] acc_out
);
    import cc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] a_next;
    logic signed [SAMPLE_BITS-1:0] b_reg;
    logic signed [SAMPLE_BITS-1:0] b_next;
    logic signed [RESULT_BITS-1:0] acc_reg;
    logic signed [RESULT_BITS-1:0] acc_next;
    logic signed [PROD_BITS-1:0]   prod;

    assign prod = a_bcast * b_reg;

    // Load on write, shift a toward cell zero and rotate b while computing
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (wr_en)
        begin
            a_next = wr_data.sample_a;
            b_next = wr_data.sample_b;
        end
        else if (cmd.compute)
        begin
            a_next = a_in;
            b_next = b_in;
        end
    end

    // Clear, accumulate one product, or shift the result toward cell zero
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.clear)
            acc_next = '0;
        else if (cmd.compute)
            acc_next = acc_reg + {{(RESULT_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
        else if (cmd.unload)
            acc_next = acc_in;
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule

// ----- hw/rtl/cc_ctrl.sv -----
// Sequencer: length register, load count, compute steps and result register.
module cc_ctrl #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cc_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [cc_pkg::DATA_BITS-1:0]          pwdata,
    output logic [cc_pkg::DATA_BITS-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic                                  result_stall,
    output logic                                  result_valid,
    output cc_pkg::cc_out_t                       result,
    input  logic signed [cc_pkg::RESULT_BITS-1:0] acc_head,
    output cc_pkg::cc_cell_cmd_t                  cmd,
    output logic                                  wr_strobe,
    output logic [$clog2(MAX_LENGTH)-1:0]         wr_idx,
    output logic [$clog2(MAX_LENGTH)-1:0]         wrap_idx
);
    import cc_pkg::*;

    localparam int IW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);

    cc_state_t         state_reg;
    cc_state_t         state_next;
    logic [LEN_BITS-1:0] blen_reg;
    logic [CW-1:0]     len_eff;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     count_plus;
    logic [IW-1:0]     step_reg;
    logic [IW-1:0]     step_next;
    logic [CW-1:0]     remain_reg;
    logic [CW-1:0]     remain_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cc_out_t           out_data_reg;
    cc_out_t           out_data_next;
    logic              accept;
    logic              move;
    logic              cfg_write;

    // Register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[ADDR_BITS-1:2] == REG_BLOCK_LENGTH);
    assign prdata    = {{(DATA_BITS-LEN_BITS){1'b0}}, blen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blen_reg <= LEN_RESET;
        else if (cfg_write)
            blen_reg <= pwdata[LEN_BITS-1:0];
    end

    // Clamp the length to 1..MAX_LENGTH
    always_comb
    begin
        if (blen_reg == '0)
            len_eff = CW'(1);
        else if (blen_reg > LEN_BITS'(MAX_LENGTH))
            len_eff = CW'(MAX_LENGTH);
        else
            len_eff = blen_reg[CW-1:0];
    end

    assign wrap_idx     = IW'(len_eff - CW'(1));
    assign wr_idx       = count_reg[IW-1:0];
    assign count_plus   = count_reg + CW'(1);
    assign sample_stall = (state_reg != S_LOAD);
    assign accept       = sample_valid && !sample_stall;
    assign move         = !out_valid_reg || !result_stall;

    // Sequence load, compute and drain
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = '0;
        wr_strobe      = 1'b0;

        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    wr_strobe = 1'b1;
                    if (count_plus >= len_eff)
                    begin
                        cmd.clear  = 1'b1;
                        count_next = '0;
                        step_next  = '0;
                        state_next = S_COMP;
                    end
                    else
                        count_next = count_plus;
                end
            end
            S_COMP:
            begin
                cmd.compute = 1'b1;
                if (step_reg == wrap_idx)
                begin
                    remain_next = len_eff;
                    state_next  = S_DRAIN;
                end
                else
                    step_next = step_reg + IW'(1);
            end
            S_DRAIN:
            begin
                if (move)
                begin
                    cmd.unload                  = 1'b1;
                    out_valid_next              = 1'b1;
                    out_data_next.result_value  = acc_head;
                    out_data_next.last_of_block = (remain_reg == CW'(1));
                    remain_next                 = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                        state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            step_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ----- hw/rtl/circular_convolution.sv -----
// Top level of the circular convolution block: sequencer and chain of cells.
//
//   channel   direction  handshake                      payload
//   samples   in         sample_valid / sample_stall    cc_in_t  (sample_a, sample_b)
//   result    out        result_valid / result_stall    cc_out_t (result_value, last_of_block)
//   config    in         APB psel/penable/pwrite        block_length at byte address 0
//
// A block of L pairs is taken one pair per cycle while loading; the pair that
// completes the block starts the compute phase, one multiply-accumulate in each
// of the L cells per cycle, then L results leave through the result register,
// one per cycle unless stalled. Samples are stalled from block completion until
// the last result enters the result register. Reset sets the length to 64 and
// empties the load count; the sample stores come out of reset undefined.
module circular_convolution #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cc_pkg::DATA_BITS-1:0] pwdata,
    output logic [cc_pkg::DATA_BITS-1:0] prdata,
    output logic                         pready,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  cc_pkg::cc_in_t               samples,
    output logic                         result_valid,
    input  logic                         result_stall,
    output cc_pkg::cc_out_t              result
);
    import cc_pkg::*;

    localparam int IW = $clog2(MAX_LENGTH);

    cc_cell_cmd_t                  cmd;
    logic                          wr_strobe;
    logic [IW-1:0]                 wr_idx;
    logic [IW-1:0]                 wrap_idx;
    logic signed [SAMPLE_BITS-1:0] a_out   [MAX_LENGTH];
    logic signed [SAMPLE_BITS-1:0] b_out   [MAX_LENGTH];
    logic signed [RESULT_BITS-1:0] acc_out [MAX_LENGTH];
    logic signed [SAMPLE_BITS-1:0] b_wrap;

    cc_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .acc_head     (acc_out[0]),
        .cmd          (cmd),
        .wr_strobe    (wr_strobe),
        .wr_idx       (wr_idx),
        .wrap_idx     (wrap_idx)
    );

    // Close the b ring at the last active cell
    assign b_wrap = b_out[wrap_idx];

    // Build the cell chain
    for (genvar i = 0; i < MAX_LENGTH; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] a_in;
        logic signed [SAMPLE_BITS-1:0] b_in;
        logic signed [RESULT_BITS-1:0] acc_in;

        if (i == MAX_LENGTH - 1)
        begin : g_tail
            assign a_in   = '0;
            assign acc_in = '0;
        end
        else
        begin : g_body
            assign a_in   = a_out[i+1];
            assign acc_in = acc_out[i+1];
        end

        if (i == 0)
        begin : g_head
            assign b_in = b_wrap;
        end
        else
        begin : g_link
            assign b_in = b_out[i-1];
        end

        cc_cell u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .wr_en   (wr_strobe && (wr_idx == IW'(i))),
            .wr_data (samples),
            .a_in    (a_in),
            .b_in    (b_in),
            .acc_in  (acc_in),
            .a_bcast (a_out[0]),
            .a_out   (a_out[i]),
            .b_out   (b_out[i]),
            .acc_out (acc_out[i])
        );
    end

endmodule
